/* sv/lqfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked queue package
// Shared constants, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lqfl_pkg;

   // Default size of the entry pool.
   localparam int ENTRY_COUNT_DEF = 1024;

   // Width of the entry index fields on the ports.
   localparam int IDX_W = 10;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // Operation codes.
   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_FREE    = 2'd1,
      FUNC_ENQUEUE = 2'd2,
      FUNC_DEQUEUE = 2'd3
   } func_type;

   // Controller to datapath commands.
   typedef struct packed {
      logic init_step;   // write one entry of the reset sweep
      logic accept;      // take the request on the ports, first phase
      logic finish;      // second phase, register the result
   } lqfl_cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic init_last;   // sweep is at the last entry
   } lqfl_stat_type;

endpackage

/* sv/lqfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked queue controller
// Sequences the reset sweep and the two phases of each item.
// ----------------------------------------------------------------------------
module lqfl_ctrl import lqfl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  lqfl_stat_type stat,
   output lqfl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.init_step = (state_ff == ST_INIT);
      cmd.accept    = (state_ff == ST_IDLE) && start;
      cmd.finish    = (state_ff == ST_FINISH);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (stat.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/lqfl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked queue datapath
// Link memory, list head and tail registers, and the result registers.
// ----------------------------------------------------------------------------
module lqfl_datapath import lqfl_pkg::*; #(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lqfl_cmd_type     cmd,
   output lqfl_stat_type    stat,
   input  logic [1:0]       req_func,
   input  logic [IDX_W-1:0] req_entry_index,
   output logic             rsp_status,
   output logic [IDX_W-1:0] rsp_result_index
);

   localparam int ADDR_W = $clog2(ENTRY_COUNT);
   localparam int LINK_W = $clog2(ENTRY_COUNT + 1);
   localparam int CMP_W  = (LINK_W > IDX_W) ? LINK_W : IDX_W;
   localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(ENTRY_COUNT);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRY_COUNT - 1);

   logic [LINK_W-1:0] link_mem [ENTRY_COUNT];

   logic [LINK_W-1:0] free_head_ff,  free_head_in;
   logic [LINK_W-1:0] queue_head_ff, queue_head_in;
   logic [LINK_W-1:0] queue_tail_ff, queue_tail_in;
   logic [ADDR_W-1:0] init_ptr_ff,   init_ptr_in;
   func_type          op_ff;
   logic [LINK_W-1:0] entry_ff;
   logic              entry_ok_ff;
   logic [LINK_W-1:0] rd_data_ff;
   logic              rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_index_ff,  rsp_index_in;

   func_type          func;
   logic              req_ok;
   logic [LINK_W-1:0] req_link;
   logic              fh_ok, qh_ok, qt_ok, rd_ok;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINK_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;

   assign func     = func_type'(req_func);
   assign req_ok   = CMP_W'(req_entry_index) < CMP_W'(ENTRY_COUNT);
   assign req_link = LINK_W'(req_entry_index);
   assign fh_ok    = free_head_ff < NIL_LINK;
   assign qh_ok    = queue_head_ff < NIL_LINK;
   assign qt_ok    = queue_tail_ff < NIL_LINK;
   assign rd_ok    = rd_data_ff < NIL_LINK;

   assign stat.init_last = (init_ptr_ff == LAST_ADDR);

   always_comb begin
      free_head_in  = free_head_ff;
      queue_head_in = queue_head_ff;
      queue_tail_in = queue_tail_ff;
      init_ptr_in   = init_ptr_ff;
      rsp_status_in = STATUS_OK;
      rsp_index_in  = '0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      if (cmd.init_step) begin
         // each entry links to its successor; the last one gets the null link
         wr_en       = 1'b1;
         wr_addr     = init_ptr_ff;
         wr_data     = LINK_W'(init_ptr_ff) + LINK_W'(1);
         init_ptr_in = init_ptr_ff + ADDR_W'(1);
      end

      if (cmd.accept) begin
         case (func)
            FUNC_ALLOC: begin
               if (fh_ok) begin
                  rd_en   = 1'b1;
                  rd_addr = free_head_ff[ADDR_W-1:0];
               end
            end
            FUNC_DEQUEUE: begin
               if (qh_ok) begin
                  rd_en   = 1'b1;
                  rd_addr = queue_head_ff[ADDR_W-1:0];
               end
            end
            FUNC_FREE: begin
               if (req_ok) begin
                  wr_en        = 1'b1;
                  wr_addr      = req_link[ADDR_W-1:0];
                  wr_data      = free_head_ff;
                  free_head_in = req_link;
               end
            end
            FUNC_ENQUEUE: begin
               if (req_ok) begin
                  wr_en   = 1'b1;
                  wr_addr = req_link[ADDR_W-1:0];
                  wr_data = NIL_LINK;
               end
            end
            default: begin
            end
         endcase
      end

      if (cmd.finish) begin
         case (op_ff)
            FUNC_ALLOC: begin
               if (fh_ok) begin
                  free_head_in = rd_data_ff;
                  wr_en        = 1'b1;
                  wr_addr      = free_head_ff[ADDR_W-1:0];
                  wr_data      = NIL_LINK;
                  rsp_index_in = IDX_W'(CMP_W'(free_head_ff));
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
            FUNC_DEQUEUE: begin
               if (qh_ok) begin
                  if (rd_ok) begin
                     queue_head_in = rd_data_ff;
                  end else begin
                     // queue drained
                     queue_head_in = NIL_LINK;
                     queue_tail_in = NIL_LINK;
                  end
                  wr_en        = 1'b1;
                  wr_addr      = queue_head_ff[ADDR_W-1:0];
                  wr_data      = NIL_LINK;
                  rsp_index_in = IDX_W'(CMP_W'(queue_head_ff));
               end else begin
                  rsp_status_in = STATUS_EMPTY;
               end
            end
            FUNC_ENQUEUE: begin
               if (entry_ok_ff) begin
                  if (qh_ok && qt_ok) begin
                     // link the old tail; a tail that is the new entry ends null
                     wr_en   = 1'b1;
                     wr_addr = queue_tail_ff[ADDR_W-1:0];
                     wr_data = (queue_tail_ff == entry_ff) ? NIL_LINK : entry_ff;
                  end else begin
                     queue_head_in = entry_ff;
                  end
                  queue_tail_in = entry_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         queue_head_ff <= NIL_LINK;
         queue_tail_ff <= NIL_LINK;
         init_ptr_ff   <= '0;
      end else begin
         free_head_ff  <= free_head_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
         init_ptr_ff   <= init_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff       <= func;
         entry_ff    <= req_link;
         entry_ok_ff <= req_ok;
      end
      if (cmd.finish) begin
         rsp_status_ff <= rsp_status_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;

endmodule

/* sv/linked_queue_with_free_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked queue with free list
// Pool of entry indices threaded through one link memory: a LIFO free list
// and a FIFO active queue.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_func (alloc, free, enqueue, dequeue) and
//   req_entry_index, raise start; the item is taken at a clock edge where
//   start is high and busy is low.
//   Result: rsp_valid strobes for one cycle with rsp_status (empty flag for
//   alloc and dequeue) and rsp_result_index (entry popped, else zero).
//   The result strobe rises at the clock edge after the item is taken.
//   Items do not overlap. For alloc and dequeue the first phase reads
//   the link memory at the list head, the second uses that link to
//   move the head. Busy drops during the result strobe, so the next item
//   may be taken while the previous result is on the ports.
//   Reset: busy stays high after reset while a sweep writes the link
//   memory so that every entry sits on the free list in ascending order;
//   the queue starts empty.
//   The receiver cannot stall: each result is taken in its strobe cycle.
// ----------------------------------------------------------------------------
module linked_queue_with_free_list import lqfl_pkg::*; #(
   parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [1:0]       req_func,
   input  logic [IDX_W-1:0] req_entry_index,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [IDX_W-1:0] rsp_result_index
);

   lqfl_cmd_type  cmd;
   lqfl_stat_type stat;

   // sequence the reset sweep and the two phases of each item
   lqfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // hold the link memory, list pointers and result registers
   lqfl_datapath #(
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index)
   );

endmodule

/* bench/tb_linked_queue_with_free_list.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked queue with free list testbench
// Drives alloc, free, enqueue and dequeue items through the start/busy port.
// A local copy of the link table, free head and queue pointers predicts each
// result. Every result strobe is checked field by field against the oldest
// prediction. A short scripted part comes first, then random phases: drain
// the free list, drain the queue, then a balanced mix with some noise.
// ----------------------------------------------------------------------------
module tb_linked_queue_with_free_list;
   import lqfl_pkg::*;

   // A link value equal to the pool size is the null link.
   localparam logic [IDX_W:0] NULL_LINK = (IDX_W + 1)'(ENTRY_COUNT_DEF);
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] entry;
   } pool_result_type;

   // One scripted item; known marks rows whose result is typed in here.
   typedef struct {
      func_type         op;
      logic [IDX_W-1:0] entry;
      bit               known;
      pool_result_type  want;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [1:0]       req_func = FUNC_ALLOC;
   logic [IDX_W-1:0] req_entry_index = '0;
   logic             rsp_valid;
   logic             rsp_status;
   logic [IDX_W-1:0] rsp_result_index;

   // Local copy of the pool state.
   logic [IDX_W:0]   link_mem [ENTRY_COUNT_DEF];
   logic [IDX_W:0]   free_top;
   logic [IDX_W:0]   queue_first;
   logic [IDX_W:0]   queue_last;

   // Predicted results in item order, oldest first.
   pool_result_type  pending_results [$];
   // Entries handed out by alloc or dequeue and not given back yet; used to
   // build well-formed free and enqueue items.
   logic [IDX_W-1:0] held_entries [$];
   int               mismatch_count = 0;

   // Scripted opening: LIFO order of the free list, FIFO order of the queue,
   // empty reports, the queue draining and refilling, enqueue of the entry
   // that is already the queue tail, and enqueue of the last entry while it
   // still ends the free list. The ignored index field carries extremes on
   // some alloc and dequeue rows.
   script_row_type script [0:23] = '{
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ALLOC,   10'd1023, 1'b1, '{STATUS_OK,    10'd1}},
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd2}},
      '{FUNC_FREE,    10'd1,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd1}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_EMPTY, 10'd0}},
      '{FUNC_ENQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ENQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ENQUEUE, 10'd2,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd2}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_EMPTY, 10'd0}},
      '{FUNC_ENQUEUE, 10'd1023, 1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ENQUEUE, 10'd1,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd1023}},
      '{FUNC_DEQUEUE, 10'd0,    1'b1, '{STATUS_OK,    10'd1}},
      '{FUNC_DEQUEUE, 10'd1023, 1'b1, '{STATUS_EMPTY, 10'd0}},
      '{FUNC_FREE,    10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_FREE,    10'd2,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd2}},
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd0}},
      '{FUNC_ALLOC,   10'd0,    1'b1, '{STATUS_OK,    10'd3}},
      '{FUNC_ENQUEUE, 10'd3,    1'b0, '{STATUS_OK,    10'd0}},
      '{FUNC_DEQUEUE, 10'd0,    1'b0, '{STATUS_OK,    10'd0}}
   };

   linked_queue_with_free_list dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index)
   );

   always #2 clock = ~clock;

   function automatic bit is_entry(input logic [IDX_W:0] link);
      return link < ENTRY_COUNT_DEF;
   endfunction

   // Apply one item to the local pool state and return its result.
   function automatic pool_result_type pool_op_result(input func_type op,
                                                      input logic [IDX_W-1:0] e);
      pool_result_type r;
      logic [IDX_W:0]  h;
      r = '{STATUS_OK, '0};
      case (op)
         FUNC_ALLOC: begin
            // Pop the free head; an empty free list changes nothing.
            h = free_top;
            if (!is_entry(h)) begin
               r.status = STATUS_EMPTY;
            end else begin
               free_top               = link_mem[h[IDX_W-1:0]];
               link_mem[h[IDX_W-1:0]] = NULL_LINK;
               r.entry                = h[IDX_W-1:0];
            end
         end
         FUNC_FREE: begin
            // Push at the free head, no matter where the entry sits now.
            if (is_entry({1'b0, e})) begin
               link_mem[e] = free_top;
               free_top    = {1'b0, e};
            end
         end
         FUNC_ENQUEUE: begin
            if (is_entry({1'b0, e})) begin
               if (is_entry(queue_first) && is_entry(queue_last)) begin
                  link_mem[queue_last[IDX_W-1:0]] = {1'b0, e};
               end else begin
                  queue_first = {1'b0, e};
               end
               queue_last  = {1'b0, e};
               link_mem[e] = NULL_LINK;
            end
         end
         default: begin
            // Dequeue: take the head; clear both pointers once drained.
            h = queue_first;
            if (!is_entry(h)) begin
               r.status = STATUS_EMPTY;
            end else begin
               queue_first = link_mem[h[IDX_W-1:0]];
               if (!is_entry(queue_first)) begin
                  queue_first = NULL_LINK;
                  queue_last  = NULL_LINK;
               end
               link_mem[h[IDX_W-1:0]] = NULL_LINK;
               r.entry                = h[IDX_W-1:0];
            end
         end
      endcase
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [IDX_W-1:0] want,
                                input logic [IDX_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
      end
   endtask

   // Present one item and hold it until taken. Start stays high on return so
   // that a following item can go out back to back.
   task automatic send_item(input func_type op, input logic [IDX_W-1:0] e,
                            input bit known, input pool_result_type want);
      pool_result_type got;
      int              hits [$];
      if (!start) begin
         start <= 1'b1;
      end
      req_func        <= op;
      req_entry_index <= e;
      do @(posedge clock); while (busy);
      // Taken at this edge: advance the local state and queue the result.
      got = pool_op_result(op, e);
      pending_results.push_back(known ? want : got);
      if (op == FUNC_ALLOC || op == FUNC_DEQUEUE) begin
         if (got.status == STATUS_OK) begin
            hits = held_entries.find_first_index(x) with (x == got.entry);
            if (hits.size() == 0) begin
               held_entries.push_back(got.entry);
            end
         end
      end else begin
         hits = held_entries.find_first_index(x) with (x == e);
         if (hits.size() != 0) begin
            held_entries.delete(hits[0]);
         end
      end
   endtask

   // Pick a random item. Well-formed free and enqueue items give back an
   // entry that is held; noise items take any operation and any index.
   task automatic pick_item(input int w_alloc, input int w_free, input int w_enq,
                            input int w_deq, input int noise_pct,
                            output func_type op, output logic [IDX_W-1:0] e);
      int roll;
      e = IDX_W'($urandom_range(ENTRY_COUNT_DEF - 1));
      if ($urandom_range(99) < noise_pct) begin
         op = func_type'($urandom_range(3));
      end else begin
         roll = $urandom_range(w_alloc + w_free + w_enq + w_deq - 1);
         if (roll < w_alloc) begin
            op = FUNC_ALLOC;
         end else if (roll < w_alloc + w_free) begin
            op = FUNC_FREE;
         end else if (roll < w_alloc + w_free + w_enq) begin
            op = FUNC_ENQUEUE;
         end else begin
            op = FUNC_DEQUEUE;
         end
         if (op == FUNC_FREE || op == FUNC_ENQUEUE) begin
            if (held_entries.size() == 0) begin
               op = FUNC_ALLOC;
            end else begin
               e = held_entries[$urandom_range(held_entries.size() - 1)];
            end
         end
      end
   endtask

   // Send count random items; after each, with the given chance, drop start
   // and idle the sender so that gaps land on both phases of the work.
   task automatic run_phase(input int count, input int w_alloc, input int w_free,
                            input int w_enq, input int w_deq, input int noise_pct,
                            input int idle_pct);
      func_type         op;
      logic [IDX_W-1:0] e;
      int               k;
      for (k = 0; k < count; k++) begin
         pick_item(w_alloc, w_free, w_enq, w_deq, noise_pct, op, e);
         send_item(op, e, 1'b0, '0);
         if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
   endtask

   // Drop start and hold off until every predicted result has come back.
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Compare every result strobe with the oldest prediction.
   always @(posedge clock) begin : check_results
      pool_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result with no item outstanding, index", '0, rsp_result_index);
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               note_mismatch("status", IDX_W'(want.status), IDX_W'(rsp_status));
            end
            if (rsp_result_index !== want.entry) begin
               note_mismatch("result_index", want.entry, rsp_result_index);
            end
         end
      end
   end

   initial begin : stimulus
      int i;
      int guard;
      // Reset image: every entry on the free list in ascending order.
      for (i = 0; i < ENTRY_COUNT_DEF; i++) begin
         link_mem[i] = (IDX_W + 1)'(i + 1);
      end
      link_mem[ENTRY_COUNT_DEF - 1] = NULL_LINK;
      free_top    = '0;
      queue_first = NULL_LINK;
      queue_last  = NULL_LINK;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // The block sweeps its link memory after reset; busy holds items off.
      @(posedge clock);

      for (i = 0; i < $size(script); i++) begin
         send_item(script[i].op, script[i].entry, script[i].known, script[i].want);
      end
      wait_drained();

      // Empty the free list with back-to-back allocs and a few enqueues,
      // running on into empty reports.
      run_phase(1150, 92, 0, 8, 0, 0, 0);
      wait_drained();
      // Drain the queue while giving entries back; sender idles half the time.
      run_phase(400, 0, 30, 15, 55, 0, 49);
      wait_drained();
      // Balanced mix with noise items that may relink listed entries.
      run_phase(400, 25, 25, 25, 25, 15, 8);
      start <= 1'b0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 100) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0d results never arrived", pending_results.size());
         mismatch_count += pending_results.size();
      end
      if (mismatch_count == 0) begin
         $display("tb_linked_queue_with_free_list: PASS");
      end else begin
         $display("tb_linked_queue_with_free_list: FAIL");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #1000000;
      $display("tb_linked_queue_with_free_list: FAIL");
      $finish;
   end

endmodule
